// ===== hdl/crop_zoom_nearest_scaler_macros.svh =====
// Assertion macros shared by the checker of the crop and zoom scaler.
`ifndef CROP_ZOOM_NEAREST_SCALER_MACROS_SVH
`define CROP_ZOOM_NEAREST_SCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CZN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CZN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/czn_pkg.sv =====
// Package of the crop and zoom scaler: widths, register codes, types and defaults.
package czn_pkg;

    // Field widths of the configuration registers.
    localparam int SIZE_W = 9;
    localparam int CROP_W = 12;
    // Remainder of the coordinate accumulator holds values below 16 * size.
    localparam int RES_W  = SIZE_W + 4;
    // Remainder plus increment stays below 32 * size.
    localparam int SUM_W  = RES_W + 1;

    localparam int PIX_PORT_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_X       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_Y       = 2'd3;

    // Register values after reset.
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [CROP_W-1:0] RST_CROP         = 12'd0;

    // Defaults of the top level parameters.
    localparam int DEF_COL_LIMIT  = 256;
    localparam int DEF_ROW_LIMIT  = 256;
    localparam int DEF_PIXEL_BITS = 32;

    // Sequencer states: normal operation, accumulator load, accumulator replay.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_INIT,
        ST_STEP
    } t_state;

    // Commands to one coordinate accumulator.
    typedef struct packed {
        logic init;
        logic step;
    } t_axis_ctl;

endpackage

// ===== hdl/czn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module czn_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/czn_axis.sv =====
// Incremental source coordinate accumulator for one axis of the scaler.
module czn_axis #(
    parameter int COORD_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [czn_pkg::SIZE_W-1:0]   i_size,
    input  logic [czn_pkg::CROP_W-1:0]   i_crop,
    input  czn_pkg::t_axis_ctl           i_ctl,
    output logic [COORD_W-1:0]           o_coord
);

    // The source coordinate of position p is floor((c*n + p*(16n - 2c)) / 16n).
    // The quotient and remainder are carried along and advanced by one position
    // per step, which takes a single add and one compare and subtract.
    logic [COORD_W-1:0]          r_q;
    logic [czn_pkg::RES_W-1:0]   r_r;
    logic [COORD_W-1:0]          n_q;
    logic [czn_pkg::RES_W-1:0]   n_r;

    logic [czn_pkg::SUM_W-1:0]   lim;
    logic [czn_pkg::SUM_W-1:0]   incr;
    logic [czn_pkg::SUM_W-1:0]   sum;
    logic [czn_pkg::RES_W-1:0]   init_r;

    // Divisor 16n and increment 16n - 2c; the increment is meaningless when
    // the visible area is empty, and the coordinate is then not used.
    assign lim    = czn_pkg::SUM_W'({i_size, 4'b0000});
    assign incr   = lim - czn_pkg::SUM_W'({i_crop, 1'b0});
    assign sum    = czn_pkg::SUM_W'(r_r) + incr;
    assign init_r = czn_pkg::RES_W'(i_crop[3:0]) * czn_pkg::RES_W'(i_size);

    // Position zero gives quotient floor(c/16) and remainder (c mod 16) * n.
    always_comb begin
        n_q = r_q;
        n_r = r_r;
        if (i_ctl.init) begin
            n_q = COORD_W'(i_crop[czn_pkg::CROP_W-1:4]);
            n_r = init_r;
        end else if (i_ctl.step) begin
            if (sum >= lim) begin
                n_q = r_q + COORD_W'(1);
                n_r = czn_pkg::RES_W'(sum - lim);
            end else begin
                n_r = czn_pkg::RES_W'(sum);
            end
        end
    end

    // Accumulator registers; reset matches position zero with no crop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_r <= '0;
        end else begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    // When the area is visible the quotient stays below the size, so no clamp.
    assign o_coord = r_q;

endmodule

// ===== hdl/crop_zoom_nearest_scaler.sv =====
// Top level of the nearest neighbor crop and zoom scaler.
// The block takes one item per clock while busy is low: a load (i_func = 0)
// writes the next source pixel of the frame store in raster order, and a
// request (i_func = 1) reads the next output pixel, which appears on o_valid
// for one cycle, in the cycle after the item is accepted, through the
// registered read of the frame store. The receiver cannot stall, so results
// are never held back. Source coordinates come from two running
// accumulators, one per axis, which move by one output position per request
// item. Every configuration write reloads them, and busy stays high after
// the write while they are loaded and then replayed up to the current output
// position (a size write returns the frame to its start). The frame store
// holds 2**(CW + RW) words of PIXEL_BITS bits and has no reset; only pixels
// of a fully loaded frame should be requested.
module crop_zoom_nearest_scaler #(
    parameter int COL_LIMIT  = czn_pkg::DEF_COL_LIMIT,
    parameter int ROW_LIMIT  = czn_pkg::DEF_ROW_LIMIT,
    parameter int PIXEL_BITS = czn_pkg::DEF_PIXEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             i_func,
    input  logic [czn_pkg::PIX_PORT_W-1:0]   i_pixel_in,
    output logic                             busy,
    output logic                             o_valid,
    output logic [czn_pkg::PIX_PORT_W-1:0]   o_pixel_out,
    output logic                             o_written,
    output logic                             o_frame_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [czn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [czn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW     = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
    localparam int RW     = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
    localparam int REB_W  = (CW > RW) ? CW : RW;
    localparam int ADDR_W = CW + RW;
    localparam int DEPTH  = 2 ** ADDR_W;

    // Configuration registers.
    logic [czn_pkg::SIZE_W-1:0] r_width;
    logic [czn_pkg::SIZE_W-1:0] r_height;
    logic [czn_pkg::CROP_W-1:0] r_crop_x;
    logic [czn_pkg::CROP_W-1:0] r_crop_y;

    // Raster counters.
    logic [CW-1:0]    r_load_col;
    logic [RW-1:0]    r_load_row;
    logic [CW-1:0]    r_out_col;
    logic [RW-1:0]    r_out_row;
    logic [REB_W-1:0] r_reb_cnt;

    // Sequencer.
    czn_pkg::t_state r_state;
    czn_pkg::t_state n_state;

    // Result stage.
    logic r_valid;
    logic r_vis;
    logic r_last;

    logic [czn_pkg::SIZE_W-1:0] w_eff;
    logic [czn_pkg::SIZE_W-1:0] h_eff;
    logic                       cfg_we;
    logic                       acc_load;
    logic                       acc_req;
    logic                       load_col_wrap;
    logic                       load_row_wrap;
    logic                       out_col_wrap;
    logic                       out_row_wrap;
    logic                       vis;
    logic                       last;
    logic                       reb_col_step;
    logic                       reb_row_step;
    czn_pkg::t_axis_ctl         col_ctl;
    czn_pkg::t_axis_ctl         row_ctl;
    logic [CW-1:0]              src_col;
    logic [RW-1:0]              src_row;
    logic [PIXEL_BITS-1:0]      rdata;

    // Effective frame size: zero counts as one, large values saturate.
    always_comb begin
        if (r_width == '0) begin
            w_eff = czn_pkg::SIZE_W'(1);
        end else if (32'(r_width) > COL_LIMIT) begin
            w_eff = czn_pkg::SIZE_W'(COL_LIMIT);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = czn_pkg::SIZE_W'(1);
        end else if (32'(r_height) > ROW_LIMIT) begin
            h_eff = czn_pkg::SIZE_W'(ROW_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    // Handshakes.
    assign cfg_we   = i_cfg_valid && o_cfg_ready;
    assign acc_load = start && !busy && !i_func;
    assign acc_req  = start && !busy && i_func;

    // Counter wrap conditions and the flags of a requested pixel.
    assign load_col_wrap = (32'(r_load_col) + 32'd1) >= 32'(w_eff);
    assign load_row_wrap = (32'(r_load_row) + 32'd1) >= 32'(h_eff);
    assign out_col_wrap  = (32'(r_out_col) + 32'd1) >= 32'(w_eff);
    assign out_row_wrap  = (32'(r_out_row) + 32'd1) >= 32'(h_eff);
    assign vis  = ({w_eff, 4'b0000} > {r_crop_x, 1'b0}) &&
                  ({h_eff, 4'b0000} > {r_crop_y, 1'b0});
    assign last = ((32'(r_out_col) + 32'd1) == 32'(w_eff)) &&
                  ((32'(r_out_row) + 32'd1) == 32'(h_eff));

    // Replay steps each axis until it reaches the current output position.
    assign reb_col_step = 32'(r_reb_cnt) < 32'(r_out_col);
    assign reb_row_step = 32'(r_reb_cnt) < 32'(r_out_row);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            czn_pkg::ST_RUN: begin
                if (cfg_we) begin
                    n_state = czn_pkg::ST_INIT;
                end
            end
            czn_pkg::ST_INIT: begin
                n_state = czn_pkg::ST_STEP;
            end
            czn_pkg::ST_STEP: begin
                if (!reb_col_step && !reb_row_step) begin
                    n_state = czn_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = czn_pkg::ST_RUN;
            end
        endcase
    end

    // Sequencer outputs: handshake levels and accumulator commands.
    // In the run state busy is low, so a request item is start with i_func.
    always_comb begin
        busy        = 1'b1;
        o_cfg_ready = 1'b0;
        col_ctl     = '0;
        row_ctl     = '0;
        case (r_state)
            czn_pkg::ST_RUN: begin
                busy        = 1'b0;
                o_cfg_ready = 1'b1;
                if (start && i_func) begin
                    if (out_col_wrap) begin
                        col_ctl.init = 1'b1;
                        if (out_row_wrap) begin
                            row_ctl.init = 1'b1;
                        end else begin
                            row_ctl.step = 1'b1;
                        end
                    end else begin
                        col_ctl.step = 1'b1;
                    end
                end
            end
            czn_pkg::ST_INIT: begin
                col_ctl.init = 1'b1;
                row_ctl.init = 1'b1;
            end
            czn_pkg::ST_STEP: begin
                col_ctl.step = reb_col_step;
                row_ctl.step = reb_row_step;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // State, configuration and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= czn_pkg::ST_RUN;
            r_width    <= czn_pkg::RST_FRAME_WIDTH;
            r_height   <= czn_pkg::RST_FRAME_HEIGHT;
            r_crop_x   <= czn_pkg::RST_CROP;
            r_crop_y   <= czn_pkg::RST_CROP;
            r_load_col <= '0;
            r_load_row <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_reb_cnt  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= acc_req;

            // Replay counter runs only during the replay state.
            if (r_state == czn_pkg::ST_STEP) begin
                r_reb_cnt <= r_reb_cnt + REB_W'(1);
            end else begin
                r_reb_cnt <= '0;
            end

            // Load position advances with every load item.
            if (acc_load) begin
                if (load_col_wrap) begin
                    r_load_col <= '0;
                    r_load_row <= load_row_wrap ? '0 : r_load_row + RW'(1);
                end else begin
                    r_load_col <= r_load_col + CW'(1);
                end
            end

            // Output position advances with every request item.
            if (acc_req) begin
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_wrap ? '0 : r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end

            // Register writes; a size change restarts both rasters.
            if (cfg_we) begin
                case (i_cfg_index)
                    czn_pkg::CFG_FRAME_WIDTH: begin
                        r_width    <= i_cfg_data[czn_pkg::SIZE_W-1:0];
                        r_load_col <= '0;
                        r_load_row <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                    end
                    czn_pkg::CFG_FRAME_HEIGHT: begin
                        r_height   <= i_cfg_data[czn_pkg::SIZE_W-1:0];
                        r_load_col <= '0;
                        r_load_row <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                    end
                    czn_pkg::CFG_CROP_X: begin
                        r_crop_x <= i_cfg_data[czn_pkg::CROP_W-1:0];
                    end
                    czn_pkg::CFG_CROP_Y: begin
                        r_crop_y <= i_cfg_data[czn_pkg::CROP_W-1:0];
                    end
                    default: begin
                        r_crop_y <= r_crop_y;
                    end
                endcase
            end
        end
    end

    // Flags of the pixel in flight through the store read.
    always_ff @(posedge i_clk) begin
        if (acc_req) begin
            r_vis  <= vis;
            r_last <= last;
        end
    end

    // Column and row accumulators.
    czn_axis #(
        .COORD_W (CW)
    ) u_col_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (w_eff),
        .i_crop  (r_crop_x),
        .i_ctl   (col_ctl),
        .o_coord (src_col)
    );

    czn_axis #(
        .COORD_W (RW)
    ) u_row_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (h_eff),
        .i_crop  (r_crop_y),
        .i_ctl   (row_ctl),
        .o_coord (src_row)
    );

    // Frame store, addressed by row and column fields.
    czn_ram #(
        .DATA_W (PIXEL_BITS),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (acc_load),
        .i_waddr ({r_load_row, r_load_col}),
        .i_wdata (i_pixel_in[PIXEL_BITS-1:0]),
        .i_raddr ({src_row, src_col}),
        .o_rdata (rdata)
    );

    // Result ports; an empty visible area gives a zero pixel.
    assign o_valid     = r_valid;
    assign o_written   = r_vis;
    assign o_frame_end = r_last;
    assign o_pixel_out = r_vis ? czn_pkg::PIX_PORT_W'(rdata) : '0;

endmodule

// ===== hdl/czn_checker.sv =====
// Port-level checker of the crop and zoom scaler and its bind to the top level.
`include "crop_zoom_nearest_scaler_macros.svh"

module czn_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           i_func,
    input logic                           busy,
    input logic                           o_valid,
    input logic                           o_written,
    input logic [czn_pkg::PIX_PORT_W-1:0] o_pixel_out,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    // Every request item gives a result in the following cycle.
    `CZN_ASSERT_NEXT(a_req_gives_result, i_clk, i_rst_n, start && !busy && i_func, o_valid, "request item gave no result")

    // A result only follows a request item.
    `CZN_ASSERT_SAME(a_result_has_request, i_clk, i_rst_n, o_valid, $past(start && !busy && i_func), "result without request item")

    // A pixel of an empty visible area reads as zero.
    `CZN_ASSERT_SAME(a_empty_pixel_zero, i_clk, i_rst_n, o_valid && !o_written, o_pixel_out == '0, "unwritten pixel is not zero")

    // A register write holds items off while the accumulators reload.
    `CZN_ASSERT_NEXT(a_cfg_sets_busy, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, busy, "no reload after register write")

endmodule

bind crop_zoom_nearest_scaler czn_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench of the nearest neighbor crop and zoom scaler.
`timescale 1ns / 1ps

// One output pixel as the block should report it.
typedef struct packed {
    logic [czn_pkg::PIX_PORT_W-1:0] pixel;
    logic                           written;
    logic                           frame_end;
} t_zoom_pixel;

// Tracks the frame store, the raster counters and the registers, and checks results.
class zoom_checker;
    localparam int MAXW = czn_pkg::DEF_COL_LIMIT;
    localparam int MAXH = czn_pkg::DEF_ROW_LIMIT;
    localparam int PBITS = czn_pkg::DEF_PIXEL_BITS;

    logic [czn_pkg::SIZE_W-1:0] width_reg;
    logic [czn_pkg::SIZE_W-1:0] height_reg;
    logic [czn_pkg::CROP_W-1:0] crop_x;
    logic [czn_pkg::CROP_W-1:0] crop_y;
    int unsigned load_col, load_row, out_col, out_row;
    logic [31:0] store [MAXW*MAXH];
    bit          loaded [MAXW*MAXH];
    t_zoom_pixel pending_pixels [$];
    int          errors;

    function new();
        width_reg  = czn_pkg::RST_FRAME_WIDTH;
        height_reg = czn_pkg::RST_FRAME_HEIGHT;
        crop_x     = czn_pkg::RST_CROP;
        crop_y     = czn_pkg::RST_CROP;
        load_col = 0; load_row = 0; out_col = 0; out_row = 0;
        errors = 0;
    endfunction

    // A zero size counts as one and sizes above the maximum saturate.
    function int unsigned clamp_size(logic [czn_pkg::SIZE_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // Exact nearest source coordinate of one output coordinate.
    function int unsigned source_coord(int unsigned pos, int unsigned n, int unsigned crop);
        longint unsigned num;
        longint unsigned q;
        num = 64'(crop) * 64'(n) + 64'(pos) * (64'(16 * n) - 64'(2 * crop));
        q = num / 64'(16 * n);
        return (q >= 64'(n)) ? n - 1 : 32'(q);
    endfunction

    function void step_pos(inout int unsigned col, inout int unsigned row,
                           input int unsigned w, input int unsigned h);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function bit visible();
        int unsigned w;
        int unsigned h;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        return (16 * w > 2 * crop_x) && (16 * h > 2 * crop_y);
    endfunction

    // Store address that the next request reads; only meaningful when visible.
    function int unsigned request_addr();
        int unsigned w;
        int unsigned h;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        return source_coord(out_row, h, crop_y) * MAXW + source_coord(out_col, w, crop_x);
    endfunction

    // A request is allowed only if it cannot read an entry never loaded.
    function bit request_safe();
        return !visible() || loaded[request_addr()];
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void write_reg(logic [czn_pkg::CFG_IDX_W-1:0] idx,
                            logic [czn_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            czn_pkg::CFG_FRAME_WIDTH: begin
                width_reg = data[czn_pkg::SIZE_W-1:0];
                load_col = 0; load_row = 0; out_col = 0; out_row = 0;
            end
            czn_pkg::CFG_FRAME_HEIGHT: begin
                height_reg = data[czn_pkg::SIZE_W-1:0];
                load_col = 0; load_row = 0; out_col = 0; out_row = 0;
            end
            czn_pkg::CFG_CROP_X: crop_x = data;
            czn_pkg::CFG_CROP_Y: crop_y = data;
            default: ;
        endcase
    endfunction

    // Updates the state for one accepted item and queues its result, if any.
    function void note_item(logic func, logic [31:0] pixel_in);
        int unsigned w;
        int unsigned h;
        int unsigned addr;
        t_zoom_pixel res;
        logic [31:0] pmask;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        pmask = (PBITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PBITS) - 32'd1);
        if (load_col >= w || load_row >= h) begin
            load_col = 0; load_row = 0;
        end
        if (out_col >= w || out_row >= h) begin
            out_col = 0; out_row = 0;
        end
        if (func == 1'b0) begin
            addr = load_row * MAXW + load_col;
            store[addr]  = pixel_in & pmask;
            loaded[addr] = 1'b1;
            step_pos(load_col, load_row, w, h);
        end else begin
            res.written   = visible();
            res.frame_end = (out_col == w - 1) && (out_row == h - 1);
            res.pixel     = res.written ? store[request_addr()] : '0;
            pending_pixels.push_back(res);
            step_pos(out_col, out_row, w, h);
        end
    endfunction

    // Prints one mismatch line and counts it.
    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_pixel(logic [31:0] pixel, logic written, logic frame_end);
        t_zoom_pixel want;
        if (pending_pixels.size() == 0) begin
            report("output pixel with no request outstanding");
            return;
        end
        want = pending_pixels.pop_front();
        if (pixel !== want.pixel)
            report($sformatf("pixel_out %08h, predicted %08h", pixel, want.pixel));
        if (written !== want.written)
            report($sformatf("written %b, predicted %b", written, want.written));
        if (frame_end !== want.frame_end)
            report($sformatf("frame_end %b, predicted %b", frame_end, want.frame_end));
    endtask
endclass

module testbench;
    localparam int NUM_PHASES = 16;
    localparam int NUM_FIXED  = 13;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             i_func = 1'b0;
    logic [czn_pkg::PIX_PORT_W-1:0]   i_pixel_in = '0;
    logic                             busy;
    logic                             o_valid;
    logic [czn_pkg::PIX_PORT_W-1:0]   o_pixel_out;
    logic                             o_written;
    logic                             o_frame_end;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [czn_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [czn_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    zoom_checker sb = new();

    crop_zoom_nearest_scaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_func      (i_func),
        .i_pixel_in  (i_pixel_in),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out),
        .o_written   (o_written),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every output pixel is checked against the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_pixel(o_pixel_out, o_written, o_frame_end);
    end

    // Presents one item and holds it until the block takes it.
    task automatic send_item(input logic func, input logic [31:0] pixel);
        start      <= 1'b1;
        i_func     <= func;
        i_pixel_in <= pixel;
        do @(posedge i_clk); while (busy);
        sb.note_item(func, pixel);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every requested pixel has come back.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The caller lowers the write valid after the last write of a group.
    task automatic write_reg(input logic [czn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [czn_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic setup_frame(input bit sizes, input logic [11:0] w, input logic [11:0] h,
                               input logic [11:0] cx, input logic [11:0] cy);
        drain();
        if (sizes) begin
            write_reg(czn_pkg::CFG_FRAME_WIDTH, w);
            write_reg(czn_pkg::CFG_FRAME_HEIGHT, h);
        end
        write_reg(czn_pkg::CFG_CROP_X, cx);
        write_reg(czn_pkg::CFG_CROP_Y, cy);
        i_cfg_valid <= 1'b0;
    endtask

    // Random mix of loads and requests; a request that would read an
    // entry never loaded is turned into a load.
    task automatic random_mix(input int count, input int req_pct, input int idle_pct);
        logic func;
        for (int i = 0; i < count; i++) begin
            idle_gap(idle_pct);
            if (i == count / 2)
                drain();
            func = ($urandom_range(99) < req_pct) && sb.request_safe();
            send_item(func, $urandom);
        end
    endtask

    // Stimulus.
    initial begin
        logic [31:0] corner_pix [8];
        logic [11:0] ph_w  [NUM_FIXED];
        logic [11:0] ph_h  [NUM_FIXED];
        logic [11:0] ph_cx [NUM_FIXED];
        logic [11:0] ph_cy [NUM_FIXED];
        bit          ph_sz [NUM_FIXED];
        int          ph_n  [NUM_FIXED];
        int          idle_pct [3];
        int          w_rand;
        int          h_rand;

        corner_pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        // Wide single row, tall single column, zero sizes with full crop,
        // saturated width, empty and barely visible crops, crop-only changes
        // in mid-frame, all-ones width with deep zoom, empty by height.
        ph_w  = '{12'd256, 12'd1,    12'd0,    12'h1FF, 12'd8,  12'd8,  12'd3,
                  12'd16,  12'd16,   12'hFFF,  12'd5,   12'd12, 12'd12};
        ph_h  = '{12'd1,   12'd256,  12'd0,    12'd2,   12'd8,  12'd8,  12'd5,
                  12'd16,  12'd16,   12'd1,    12'd7,   12'd3,  12'd3};
        ph_cx = '{12'd0,   12'd0,    12'hFFF,  12'd100, 12'd64, 12'd63, 12'd7,
                  12'd100, 12'd8,    12'd2040, 12'd0,   12'd50, 12'd0};
        ph_cy = '{12'd0,   12'd1000, 12'd0,    12'd0,   12'd0,  12'd63, 12'd30,
                  12'd127, 12'd200,  12'd0,    12'd55,  12'd20, 12'hFFF};
        ph_sz = '{1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 1, 1, 0};
        ph_n  = '{100, 100, 50, 100, 50, 50, 50, 60, 60, 120, 50, 50, 40};
        // Sender never idle, mostly idle, and often idle.
        idle_pct = '{0, 82, 34};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 4x2 frame of corner values, read back unscaled, then zoomed
        // by a crop of one pixel in x and half in y, then with an empty visible area.
        setup_frame(1, 12'd4, 12'd2, 12'd0, 12'd0);
        for (int i = 0; i < 8; i++) send_item(1'b0, corner_pix[i]);
        for (int i = 0; i < 8; i++) send_item(1'b1, '0);
        setup_frame(0, 12'd0, 12'd0, 12'd16, 12'd8);
        for (int i = 0; i < 6; i++) send_item(1'b1, '0);
        setup_frame(0, 12'd0, 12'd0, 12'hFFF, 12'd0);
        for (int i = 0; i < 2; i++) send_item(1'b1, '0);

        // Random phases across register settings and idling patterns.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_FIXED) begin
                setup_frame(ph_sz[p], ph_w[p], ph_h[p], ph_cx[p], ph_cy[p]);
                random_mix(ph_n[p], 30 + 20 * (p % 3), idle_pct[p % 3]);
            end else begin
                w_rand = $urandom_range(12, 1);
                h_rand = $urandom_range(8, 1);
                setup_frame(1, 12'(w_rand), 12'(h_rand),
                            12'($urandom_range(16 * w_rand, 0)),
                            12'($urandom_range(16 * h_rand, 0)));
                random_mix(70, 55, idle_pct[p % 3]);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/czn_pkg.sv
hdl/czn_ram.sv
hdl/czn_axis.sv
hdl/crop_zoom_nearest_scaler.sv
hdl/czn_checker.sv
tb/testbench.sv
